@@ rtl/core/kprq_pkg.sv @@
// ----------------------------------------------------------------------------
// kprq_pkg
// Shared types and codes for the keyed priority request queue: operation
// and status codes, entry layout, channel payloads and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package kprq_pkg;

    localparam int unsigned OCC_W = 5;

    typedef enum logic [1:0] {
        K_ENQUEUE = 2'd0,
        K_DEQUEUE = 2'd1,
        K_FIND    = 2'd2,
        K_REMOVE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef logic [OCC_W-1:0] t_occ;

    typedef struct packed {
        logic [15:0] requester;
        logic [1:0]  priority_lvl;
        logic [15:0] resource;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] requester_id;
        logic [1:0]  priority_req;
        logic [15:0] resource_id;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_requester;
        logic [1:0]  out_priority;
        logic [15:0] out_resource;
        t_occ        occupancy;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_ISSUE,
        S_SHIFT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/kprq_ram.sv @@
// ----------------------------------------------------------------------------
// kprq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kprq_ram #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/keyed_priority_request_queue_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_priority_request_queue_unit
// Bounded request table kept packed in arrival order in a RAM. Enqueue
// appends; dequeue, find and remove scan the table with one shared compare
// unit, and dequeue/remove then close the gap one slot per cycle.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        i_in_valid / o_in_ready / i_in_data       request transfer in
//  out       o_out_valid / i_out_ready / o_out_data    one result per request
//
//  Find and remove scan until a match, dequeue scans every entry; dequeue
//  and remove then shift the slots behind the chosen entry down. The single
//  RAM read port limits scans and shifts to one slot per cycle.
//  One request at a time; a finished result holds the sequencer only while
//  the previous result is still untaken in the output register.
//  Reset clears the entry count and control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_priority_request_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kprq_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kprq_pkg::t_out_item     o_out_data
);

    import kprq_pkg::*;

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    logic              r_hit, n_hit;
    t_entry            r_best, n_best;
    t_in_item          r_item, n_item;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_q;

    logic              in_xfer;
    logic              out_free;
    logic [CNT_W-1:0]  idx_ext, best_ext;
    logic              match_res, match_both, better;
    logic              scan_last, find_hit, rem_hit, deq_hit_now;
    logic              best_is_last, shift_last;

    kprq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_q     = t_entry'(ram_rdata);
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign idx_ext  = CNT_W'(r_idx);
    assign best_ext = CNT_W'(r_best_idx);

    // shared compare unit: one slot per cycle against the held request
    assign match_res   = rd_q.resource == r_item.resource_id;
    assign match_both  = match_res && (rd_q.requester == r_item.requester_id);
    assign better      = match_res && (!r_hit || (rd_q.priority_lvl < r_best.priority_lvl));
    assign scan_last   = (idx_ext + CNT_W'(1)) == r_count;
    assign find_hit    = (r_item.kind == K_FIND) && match_res;
    assign rem_hit     = (r_item.kind == K_REMOVE) && match_both;
    assign deq_hit_now = r_hit || better;
    assign best_is_last = (best_ext + CNT_W'(1)) == r_count;
    assign shift_last   = (idx_ext + CNT_W'(2)) == r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.kind == K_ENQUEUE || r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (find_hit) begin
                    n_state = S_FINISH;
                end else if (rem_hit) begin
                    n_state = S_SHIFT_ISSUE;
                end else if (scan_last) begin
                    if (r_item.kind == K_DEQUEUE && deq_hit_now) begin
                        n_state = S_SHIFT_ISSUE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SHIFT_ISSUE: begin
                n_state = best_is_last ? S_FINISH : S_SHIFT;
            end
            S_SHIFT: begin
                if (shift_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_best_idx  = r_best_idx;
        n_hit       = r_hit;
        n_best      = r_best;
        n_item      = r_item;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = IDX_W'(r_count);
        ram_wdata   = '{requester:    i_in_data.requester_id,
                        priority_lvl: i_in_data.priority_req,
                        resource:     i_in_data.resource_id};
        ram_raddr   = '0;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    n_item   = i_in_data;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_status = ST_NONE;
                    if (i_in_data.kind == K_ENQUEUE) begin
                        if (r_count < CNT_W'(QUEUE_DEPTH)) begin
                            ram_we   = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_status = ST_OK;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = IDX_W'(idx_ext + CNT_W'(1));
                n_idx     = IDX_W'(idx_ext + CNT_W'(1));
                if (find_hit) begin
                    n_best   = rd_q;
                    n_status = ST_OK;
                end else if (rem_hit) begin
                    n_best_idx = r_idx;
                    n_status   = ST_OK;
                end else if (r_item.kind == K_DEQUEUE) begin
                    if (better) begin
                        n_best     = rd_q;
                        n_best_idx = r_idx;
                        n_hit      = 1'b1;
                    end
                    if (scan_last && deq_hit_now) begin
                        n_status = ST_OK;
                    end
                end
            end
            S_SHIFT_ISSUE: begin
                ram_raddr = IDX_W'(best_ext + CNT_W'(1));
                n_idx     = r_best_idx;
                if (best_is_last) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_SHIFT: begin
                // data of slot idx+1 moves down into slot idx
                ram_raddr = IDX_W'(idx_ext + CNT_W'(2));
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = rd_q;
                n_idx     = IDX_W'(idx_ext + CNT_W'(1));
                if (shift_last) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.occupancy   = t_occ'(r_count);
                    if (r_status == ST_OK &&
                        (r_item.kind == K_DEQUEUE || r_item.kind == K_FIND)) begin
                        n_out.out_requester = r_best.requester;
                        n_out.out_priority  = r_best.priority_lvl;
                        n_out.out_resource  = r_best.resource;
                    end else begin
                        n_out.out_requester = '0;
                        n_out.out_priority  = '0;
                        n_out.out_resource  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_item     <= n_item;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
